// File: sv/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the allocation range table.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int TableDepthDefault = 64;
   localparam int AddrBitsDefault   = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_FREE   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NULL      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   localparam logic [1:0] KIND_STACK = 2'd1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type status;
      logic [15:0] tag;
      logic [7:0]  ctx;
      logic [31:0] offset;
   } rsp_type;

endpackage

// File: sv/allocation_range_table_core.sv
// ----------------------------------------------------------------------------
// allocation_range_table_core
// Table of allocations with insert, best-base lookup and stack free.
// ----------------------------------------------------------------------------
// channel | dir | fields (low bit up)
// req     | in  | tdata: address[31:0] object_tag[47:32] context_id[55:48], 56 bits
//         |     | tuser: operation[1:0] alloc_kind[3:2]
// rsp     | out | tdata: status[2:0] found_tag[18:3] found_context[26:19]
//         |     | offset[58:27], 64 bits
// Each transaction walks the table memory, one entry a cycle, set by the
// single read port; the result is then registered, and a new transaction
// is not taken until the last one is done.
// After reset a clearing pass writes every entry to zero; req_tready is low.
// A result waits in the output register; req_tready stays low until it leaves.
// ----------------------------------------------------------------------------
module allocation_range_table_core
   import art_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int ADDR_BITS   = AddrBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // address, object_tag, context_id
   input  logic [3:0]  req_tuser,  // operation, alloc_kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // status, found_tag, found_context, offset
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int EW = ADDR_BITS + 16 + 8 + 2;

   // entry: valid, stack, ctx, tag, base
   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_ff;
   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic [EW-1:0] wr_data;

   state_type state_ff, state_in;
   logic [IW:0] idx_ff, idx_in;
   op_type op_ff, op_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [15:0] tag_ff, tag_in;
   logic [7:0]  ctx_ff, ctx_in;
   logic        stk_ff, stk_in;
   logic        dup_ff, dup_in, hasfree_ff, hasfree_in, best_ok_ff, best_ok_in;
   logic [IW-1:0] free_ff, free_in;
   logic [ADDR_BITS-1:0] bbase_ff, bbase_in;
   logic [15:0] btag_ff, btag_in;
   logic [7:0]  bctx_ff, bctx_in;
   logic        ov_ff, ov_in;
   rsp_type     rsp_ff, rsp_in;

   logic [ADDR_BITS-1:0] e_base;
   logic [15:0] e_tag;
   logic [7:0]  e_ctx;
   logic        e_stk, e_val;
   logic [IW:0] eidx;
   logic [ADDR_BITS-1:0] diff;

   assign e_base = rd_ff[ADDR_BITS-1:0];
   assign e_tag  = rd_ff[ADDR_BITS +: 16];
   assign e_ctx  = rd_ff[ADDR_BITS+16 +: 8];
   assign e_stk  = rd_ff[ADDR_BITS+24];
   assign e_val  = rd_ff[ADDR_BITS+25];
   assign eidx   = idx_ff - 1'b1;
   assign diff   = addr_ff - bbase_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_ff <= mem[idx_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         ov_ff    <= ov_in;
      end
      op_ff <= op_in; addr_ff <= addr_in; tag_ff <= tag_in; ctx_ff <= ctx_in;
      stk_ff <= stk_in; dup_ff <= dup_in; hasfree_ff <= hasfree_in;
      best_ok_ff <= best_ok_in; free_ff <= free_in; bbase_ff <= bbase_in;
      btag_ff <= btag_in; bctx_ff <= bctx_in; rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; ov_in = ov_ff;
      op_in = op_ff; addr_in = addr_ff; tag_in = tag_ff; ctx_in = ctx_ff;
      stk_in = stk_ff; dup_in = dup_ff; hasfree_in = hasfree_ff;
      best_ok_in = best_ok_ff; free_in = free_ff; bbase_in = bbase_ff;
      btag_in = btag_ff; bctx_in = bctx_ff; rsp_in = rsp_ff;
      wr_en = 1'b0; wr_idx = eidx[IW-1:0]; wr_data = rd_ff;
      req_tready = 1'b0;
      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1; wr_idx = idx_ff[IW-1:0]; wr_data = '0;
            if (idx_ff == (IW+1)'(TABLE_DEPTH - 1)) begin
               idx_in = '0; state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_tready = !ov_ff;
            if (req_tvalid && !ov_ff) begin
               op_in   = op_type'(req_tuser[1:0]);
               addr_in = ADDR_BITS'(req_tdata[31:0]);
               tag_in  = req_tdata[47:32];
               ctx_in  = req_tdata[55:48];
               stk_in  = (req_tuser[3:2] == KIND_STACK);
               dup_in = 1'b0; hasfree_in = 1'b0; best_ok_in = 1'b0;
               free_in = '0; bbase_in = '0; btag_in = '0; bctx_in = '0;
               idx_in = (IW+1)'(1);
               state_in = S_READ;
            end
         end
         S_READ: begin
            // rd_ff now holds entry eidx; advance the read address
            if (e_val) begin
               case (op_ff)
                  OP_INSERT: if (e_base == addr_ff) dup_in = 1'b1;
                  OP_LOOKUP: if (e_base <= addr_ff && (!best_ok_ff || e_base > bbase_ff)) begin
                     best_ok_in = 1'b1; bbase_in = e_base; btag_in = e_tag; bctx_in = e_ctx;
                  end
                  OP_FREE: if (e_stk && e_ctx == ctx_ff) begin
                     wr_en = 1'b1; wr_data = '0;
                  end
                  default: ;
               endcase
            end else if (!hasfree_ff) begin
               hasfree_in = 1'b1; free_in = eidx[IW-1:0];
            end
            if (idx_ff == (IW+1)'(TABLE_DEPTH)) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            rsp_in = '{status: ST_OK, tag: '0, ctx: '0, offset: '0};
            case (op_ff)
               OP_INSERT: begin
                  if (dup_ff) rsp_in.status = ST_DUPLICATE;
                  else if (!hasfree_ff) rsp_in.status = ST_FULL;
                  else begin
                     wr_en = 1'b1; wr_idx = free_ff;
                     wr_data = {1'b1, stk_ff, ctx_ff, tag_ff, addr_ff};
                     rsp_in.tag = tag_ff; rsp_in.ctx = ctx_ff;
                  end
               end
               OP_LOOKUP: begin
                  if (addr_ff == '0) rsp_in.status = ST_NULL;
                  else if (!best_ok_ff) rsp_in.status = ST_NOT_FOUND;
                  else begin
                     rsp_in.tag = btag_ff; rsp_in.ctx = bctx_ff;
                     rsp_in.offset = 32'(diff);
                  end
               end
               OP_FREE: ;
               default: rsp_in.status = ST_NOT_FOUND;
            endcase
            ov_in = 1'b1;
            idx_in = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.offset, rsp_ff.ctx, rsp_ff.tag, rsp_ff.status};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_tvalid) else $error("result missing");

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for allocation_range_table_core: a directed table of
// inserts, lookups and frees, then random traffic with bursty input and a
// stalling output, each result checked against an allocation table model.
// ----------------------------------------------------------------------------
module testbench;
   import art_pkg::*;

   localparam int Depth = 64;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  ctx;
      logic [15:0] tag;
      logic [31:0] addr;
      op_type      op;
   } alloc_req_type;

   typedef struct {
      alloc_req_type req;
      logic          has_rsp;
      rsp_type       rsp;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   logic [31:0] mdl_base [Depth];
   logic [15:0] mdl_tag [Depth];
   logic [7:0]  mdl_ctx [Depth];
   logic        mdl_stack [Depth];
   logic        mdl_valid [Depth];

   rsp_type     pending_rsp [$];
   vector_type  vectors [$];
   int          errors = 0;
   int          rsp_count = 0;
   int          counts [4] = '{0, 0, 0, 0};
   bit          long_hold = 1'b0;
   bit          stim_done = 1'b0;
   logic [31:0] used_bases [$];

   always #6 clock = ~clock;

   allocation_range_table_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   function automatic rsp_type make_rsp(status_type st, logic [15:0] tag, logic [7:0] ctx,
                                        logic [31:0] offset);
      rsp_type r;
      r.status = st;
      r.tag = tag;
      r.ctx = ctx;
      r.offset = offset;
      return r;
   endfunction

   function automatic rsp_type apply_alloc_op(alloc_req_type q);
      int slot;
      int best;
      slot = -1;
      best = -1;
      case (q.op)
         OP_INSERT: begin
            for (int i = 0; i < Depth; i++) begin
               if (mdl_valid[i] && mdl_base[i] == q.addr)
                  return make_rsp(ST_DUPLICATE, '0, '0, '0);
               if (!mdl_valid[i] && slot < 0)
                  slot = i;
            end
            if (slot < 0)
               return make_rsp(ST_FULL, '0, '0, '0);
            mdl_base[slot] = q.addr;
            mdl_tag[slot] = q.tag;
            mdl_ctx[slot] = q.ctx;
            mdl_stack[slot] = (q.kind == KIND_STACK);
            mdl_valid[slot] = 1'b1;
            return make_rsp(ST_OK, q.tag, q.ctx, '0);
         end
         OP_LOOKUP: begin
            if (q.addr == '0)
               return make_rsp(ST_NULL, '0, '0, '0);
            for (int i = 0; i < Depth; i++)
               if (mdl_valid[i] && mdl_base[i] <= q.addr &&
                   (best < 0 || mdl_base[i] > mdl_base[best]))
                  best = i;
            if (best < 0)
               return make_rsp(ST_NOT_FOUND, '0, '0, '0);
            return make_rsp(ST_OK, mdl_tag[best], mdl_ctx[best], q.addr - mdl_base[best]);
         end
         OP_FREE: begin
            for (int i = 0; i < Depth; i++)
               if (mdl_valid[i] && mdl_stack[i] && mdl_ctx[i] == q.ctx)
                  mdl_valid[i] = 1'b0;
            return make_rsp(ST_OK, '0, '0, '0);
         end
         default: return make_rsp(ST_NOT_FOUND, '0, '0, '0);
      endcase
   endfunction

   task automatic report(string what, rsp_type got, rsp_type want);
      errors++;
      $display("mismatch %s at result %0d: got st=%0d tag=%h ctx=%h off=%h, %s%0d %s%h %s%h %s%h",
               what, rsp_count, got.status, got.tag, got.ctx, got.offset,
               "want st=", want.status, "tag=", want.tag, "ctx=", want.ctx,
               "off=", want.offset);
   endtask

   task automatic send_req(alloc_req_type q, logic has, rsp_type typed);
      rsp_type want;
      req_tvalid <= 1'b1;
      req_tdata <= {q.ctx, q.tag, q.addr};
      req_tuser <= {q.kind, q.op};
      do @(posedge clock); while (!req_tready);
      want = apply_alloc_op(q);
      counts[q.op]++;
      if (has && want != typed)
         report("directed row", typed, want);
      pending_rsp.insert(pending_rsp.size(), has ? typed : want);
   endtask

   task automatic idle_req(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic alloc_req_type rnd_req();
      alloc_req_type q;
      int sel;
      q.tag = 16'($urandom);
      q.ctx = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) q.ctx = 8'($urandom);
      q.kind = 2'($urandom_range(0, 3));
      sel = $urandom_range(0, 99);
      if (sel < 30) q.op = OP_INSERT;
      else if (sel < 85) q.op = OP_LOOKUP;
      else if (sel < 97) q.op = OP_FREE;
      else q.op = OP_NONE;
      q.addr = $urandom;
      if (q.op == OP_INSERT && used_bases.size() > 0 && $urandom_range(0, 7) == 0)
         q.addr = used_bases[$urandom_range(0, used_bases.size() - 1)];
      else if (q.op == OP_LOOKUP && used_bases.size() > 0 && $urandom_range(0, 3) != 0)
         q.addr = used_bases[$urandom_range(0, used_bases.size() - 1)] + $urandom_range(0, 255);
      else if (q.op == OP_LOOKUP && $urandom_range(0, 19) == 0)
         q.addr = '0;
      if (q.op == OP_INSERT)
         used_bases.insert(used_bases.size(), q.addr);
      return q;
   endfunction

   function automatic alloc_req_type mk(op_type op, logic [31:0] a, logic [15:0] t,
                                        logic [7:0] c, logic [1:0] k);
      alloc_req_type q;
      q.op = op; q.addr = a; q.tag = t; q.ctx = c; q.kind = k;
      return q;
   endfunction

   task automatic add_row(alloc_req_type q, logic has, rsp_type r);
      vector_type v;
      v.req = q; v.has_rsp = has; v.rsp = r;
      vectors.insert(vectors.size(), v);
   endtask

   initial begin
      rsp_type none;
      none = make_rsp(ST_OK, '0, '0, '0);
      foreach (mdl_valid[i]) begin
         mdl_valid[i] = 1'b0; mdl_base[i] = '0; mdl_tag[i] = '0;
         mdl_ctx[i] = '0; mdl_stack[i] = 1'b0;
      end
      add_row(mk(OP_LOOKUP, 32'h0, 16'h0, 8'h0, 2'd0), 1, make_rsp(ST_NULL, '0, '0, '0));
      add_row(mk(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 8'h0, 2'd0), 1,
              make_rsp(ST_NOT_FOUND, '0, '0, '0));
      add_row(mk(OP_INSERT, 32'h1000, 16'hFFFF, 8'hFF, 2'd1), 1,
              make_rsp(ST_OK, 16'hFFFF, 8'hFF, '0));
      add_row(mk(OP_INSERT, 32'h1000, 16'h1234, 8'h01, 2'd0), 1,
              make_rsp(ST_DUPLICATE, '0, '0, '0));
      add_row(mk(OP_INSERT, 32'hFFFF_FFFF, 16'hA5A5, 8'h00, 2'd2), 1,
              make_rsp(ST_OK, 16'hA5A5, 8'h00, '0));
      add_row(mk(OP_INSERT, 32'h0, 16'h0001, 8'h02, 2'd3), 1,
              make_rsp(ST_OK, 16'h0001, 8'h02, '0));
      add_row(mk(OP_INSERT, 32'h2000, 16'h5A5A, 8'hFF, 2'd1), 0, none);
      add_row(mk(OP_LOOKUP, 32'h0FFF, 16'hFFFF, 8'hFF, 2'd3), 0, none);
      add_row(mk(OP_LOOKUP, 32'h1010, 16'h0, 8'h0, 2'd0), 1,
              make_rsp(ST_OK, 16'hFFFF, 8'hFF, 32'h10));
      add_row(mk(OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 8'h0, 2'd0), 1,
              make_rsp(ST_OK, 16'hA5A5, 8'h00, '0));
      add_row(mk(OP_LOOKUP, 32'h2FFF, 16'h0, 8'h0, 2'd0), 0, none);
      add_row(mk(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 2'd3), 1,
              make_rsp(ST_NOT_FOUND, '0, '0, '0));
      add_row(mk(OP_FREE, 32'h0, 16'h0, 8'hFF, 2'd0), 1, none);
      add_row(mk(OP_LOOKUP, 32'h2FFF, 16'h0, 8'h0, 2'd0), 1,
              make_rsp(ST_OK, 16'h0001, 8'h02, 32'h2FFF));
      add_row(mk(OP_FREE, 32'h0, 16'h0, 8'h42, 2'd0), 1, none);
      for (int i = 0; i < 62; i++)
         add_row(mk(OP_INSERT, 32'h8000_0000 + i * 16, 16'(i), 8'(i), 2'(i % 3)), 0, none);
      add_row(mk(OP_INSERT, 32'h4000, 16'h0, 8'h0, 2'd0), 1, make_rsp(ST_FULL, '0, '0, '0));
      for (int i = 0; i < 8; i++)
         add_row(mk(OP_FREE, 32'h0, 16'h0, 8'(i), 2'd0), 0, none);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (vectors[i]) begin
         send_req(vectors[i].req, vectors[i].has_rsp, vectors[i].rsp);
         if ($urandom_range(0, 3) == 0) idle_req($urandom_range(1, 5));
      end
      idle_req(1);
      long_hold = 1'b1;
      for (int n = 0; n < 364; ) begin
         int burst;
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++, n++)
            send_req(rnd_req(), 0, none);
         if (n > 200 && n < 215) begin
            idle_req(1);
            wait (pending_rsp.size() == 0);
         end
         idle_req($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 80));
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
         end
         if ($urandom_range(0, 49) == 0) begin
            hold = $urandom_range(5, 150);
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tdata[2:0]);
         got.tag    = rsp_tdata[18:3];
         got.ctx    = rsp_tdata[26:19];
         got.offset = rsp_tdata[58:27];
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("unexpected result transaction %0d", rsp_count);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status != want.status) report("status", got, want);
            if (got.tag != want.tag) report("found_tag", got, want);
            if (got.ctx != want.ctx) report("found_context", got, want);
            if (got.offset != want.offset) report("offset", got, want);
         end
      end
   end

   initial begin
      wait (stim_done);
      wait (pending_rsp.size() == 0);
      repeat (4 * Depth) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         errors++;
         $display("%0d results never arrived", pending_rsp.size());
      end
      $display("covered %0d inserts, %0d lookups, %0d frees, %0d invalid ops; %0d results",
               counts[0], counts[1], counts[2], counts[3], rsp_count);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #20000000;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
sv/art_pkg.sv
sv/allocation_range_table_core.sv
dv/testbench.sv
